// ===== sv/gbba_pkg.sv =====
// Shared constants and types of the group bitmap block allocator.
`timescale 1ns / 1ps
`default_nettype none
package gbba_pkg;

    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 17;

    localparam int CMD_W    = 1;
    localparam int STATUS_W = 2;
    localparam int BLOCK_W  = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_GROUP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INODES_IN_GROUP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUPS_IN_USE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_BLOCK = 2'd3;

    // Request into the shared divider.
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } t_div_req;

    // Answer of the shared divider; done pulses for one cycle.
    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
        logic [DIV_DEN_W-1:0] remainder;
    } t_div_rsp;

endpackage
`default_nettype wire

// ===== sv/gbba_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module gbba_divider
    import gbba_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 r_busy, n_busy;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [DIV_DEN_W:0]   r_rem, n_rem;
    logic [DIV_NUM_W-1:0] r_quo, n_quo;
    logic [DIV_DEN_W-1:0] r_den, n_den;
    logic                 r_done, n_done;
    logic [DIV_DEN_W+1:0] w_shift;
    logic [DIV_DEN_W+1:0] w_diff;

    assign w_shift = {r_rem, r_quo[DIV_NUM_W-1]};
    assign w_diff  = w_shift - {2'b00, r_den};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_den  = i_req.divisor;
        end else if (r_busy) begin
            // The remainder stays below the divisor, so one subtract decides the bit.
            if (!w_diff[DIV_DEN_W+1]) begin
                n_rem = w_diff[DIV_DEN_W:0];
                n_quo = {r_quo[DIV_NUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_shift[DIV_DEN_W:0];
                n_quo = {r_quo[DIV_NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem[DIV_DEN_W-1:0];

endmodule
`default_nettype wire

// ===== sv/group_bitmap_block_allocator.sv =====
// Top level of the group bitmap block allocator.
`timescale 1ns / 1ps
`default_nettype none
// Allocates and frees blocks over up to MAX_GROUPS block groups. Each group is tracked by a
// used-block bitmap held in one memory of BITMAP_WORD_BITS-bit words, and the word width is a
// power of two. After reset the block clears all ceil(MAX_GROUPS * MAX_BLOCKS_PER_GROUP /
// BITMAP_WORD_BITS) bitmap words (2048 by default) and accepts no word meanwhile. One item is
// handled at a time. Every item first goes through a division in the shared divider: the
// preferred group of an allocate, or the group and bit of a free. An item with a bad group
// then goes straight to the result step. A free then takes an address step, a
// read-modify-write of one bitmap word and a result step. An allocate passes a group step
// for each group it visits, an address step for each visited group with a nonzero free
// count, and a memory read step then an evaluate step for each bitmap word scanned. While
// the result register still holds a word that has not been taken, the block waits in its
// result step.
module group_bitmap_block_allocator
    import gbba_pkg::*;
#(
    parameter int MAX_GROUPS           = 16,
    parameter int MAX_BLOCKS_PER_GROUP = 8192,
    parameter int BITMAP_WORD_BITS     = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [63:0]           s_axis_tdata,  // owner_inode[31:0], block_number[63:32]
    input  wire logic [CMD_W-1:0]      s_axis_tuser,  // command[0]
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [39:0]                m_axis_tdata   // status[1:0], allocated_block[19:2],
                                                      // free_total[37:20], zero[39:38]
);

    localparam int MAXB   = MAX_BLOCKS_PER_GROUP;
    localparam int W      = BITMAP_WORD_BITS;
    localparam int WORDS  = (MAX_GROUPS * MAXB + W - 1) / W;
    localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int GW     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int NGW    = $clog2(MAX_GROUPS + 1);
    localparam int OW     = $clog2(W);
    localparam int BPGW   = $clog2(MAXB + 1);
    localparam int BW     = $clog2(MAXB + W + 1);
    localparam int CNT_W  = 14;
    localparam int RST_BPG = (MAXB < 8192) ? MAXB : 8192;
    localparam int RST_GRP = (MAX_GROUPS < 16) ? MAX_GROUPS : 16;
    localparam logic [CNT_W-1:0]   RST_GCNT  = CNT_W'(RST_BPG);
    localparam logic [BLOCK_W-1:0] RST_TOTAL = BLOCK_W'(RST_GRP * RST_BPG);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_DIV1  = 8'b0000_0100,
        S_GRP   = 8'b0000_1000,
        S_ADDR  = 8'b0001_0000,
        S_RD    = 8'b0010_0000,
        S_EVAL  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [13:0] r_cfg_bpg;
    logic [16:0] r_cfg_ipg;
    logic [4:0]  r_cfg_groups;
    logic        r_cfg_fdb;

    // Item and scan registers.
    logic [CMD_W-1:0] r_cmd, n_cmd;
    logic [31:0]      r_inode, n_inode;
    logic [31:0]      r_blk, n_blk;
    logic [GW-1:0]    r_g, n_g;
    logic [NGW-1:0]   r_left, n_left;
    logic [BW-1:0]    r_b, n_b;
    logic [AW-1:0]    r_word, n_word;
    logic [OW-1:0]    r_off, n_off;
    logic [AW-1:0]    r_clr, n_clr;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [BLOCK_W-1:0]  r_granted, n_granted;

    logic [CNT_W-1:0]   r_gcnt [MAX_GROUPS];
    logic [BLOCK_W-1:0] r_total;
    logic               w_gcnt_dec, w_gcnt_inc;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [BLOCK_W-1:0]  r_out_block;
    logic [BLOCK_W-1:0]  r_out_total;

    // Bitmap memory.
    logic [W-1:0]  r_mem [WORDS];
    logic [W-1:0]  r_rdata;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [W-1:0]  w_wdata;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    // Effective register values.
    logic [BPGW-1:0] w_bpg;
    logic [16:0]     w_ipg;
    logic [NGW-1:0]  w_ngroups;

    always_comb begin
        if (r_cfg_bpg == '0) begin
            w_bpg = BPGW'(1);
        end else if ({2'b00, r_cfg_bpg} > 16'(MAXB)) begin
            w_bpg = BPGW'(MAXB);
        end else begin
            w_bpg = BPGW'(r_cfg_bpg);
        end
        w_ipg = (r_cfg_ipg == '0) ? 17'd1 : r_cfg_ipg;
        if ({4'b0000, r_cfg_groups} > 9'(MAX_GROUPS)) begin
            w_ngroups = NGW'(MAX_GROUPS);
        end else begin
            w_ngroups = NGW'(r_cfg_groups);
        end
    end

    gbba_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Scan of one word: candidates are clear bits from r_off on, within the group.
    logic [BW-1:0] w_remain;
    logic [W-1:0]  w_cand;
    logic [W-1:0]  w_low;
    logic [OW-1:0] w_pos;
    logic          w_found;
    logic [BW-1:0] w_b_hit;
    logic [BW-1:0] w_b_next;
    logic          w_g_last;
    logic [31:0]   w_base_idx;

    assign w_remain = BW'(w_bpg) - r_b;

    always_comb begin
        for (int j = 0; j < W; j++) begin
            w_cand[j] = !r_rdata[j] && (OW'(j) >= r_off)
                        && (BW'(OW'(j) - r_off) < w_remain);
        end
        w_low = w_cand & (~w_cand + 1'b1);
        w_pos = '0;
        for (int j = 0; j < W; j++) begin
            if (w_low[j]) begin
                w_pos = w_pos | OW'(j);
            end
        end
        w_found = |w_cand;
    end

    assign w_b_hit    = r_b + BW'(w_pos - r_off);
    assign w_b_next   = r_b + BW'(W) - BW'(r_off);
    assign w_g_last   = (NGW'(r_g) + 1'b1) >= w_ngroups;
    assign w_base_idx = 32'(r_g) * 32'(MAXB) + 32'(r_b);

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_inode   = r_inode;
        n_blk     = r_blk;
        n_g       = r_g;
        n_left    = r_left;
        n_b       = r_b;
        n_word    = r_word;
        n_off     = r_off;
        n_clr     = r_clr;
        n_status  = r_status;
        n_granted = r_granted;
        w_div_req = '0;
        w_we      = 1'b0;
        w_waddr   = r_word;
        w_wdata   = r_rdata;
        w_gcnt_dec = 1'b0;
        w_gcnt_inc = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == AW'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd     = s_axis_tuser;
                    n_inode   = s_axis_tdata[31:0];
                    n_blk     = s_axis_tdata[63:32];
                    n_status  = ST_OK;
                    n_granted = '0;
                    w_div_req.start = 1'b1;
                    if (s_axis_tuser == CMD_FREE) begin
                        w_div_req.dividend = s_axis_tdata[63:32] - 32'(r_cfg_fdb);
                        w_div_req.divisor  = DIV_DEN_W'(w_bpg);
                    end else begin
                        w_div_req.dividend = s_axis_tdata[31:0] - 32'd1;
                        w_div_req.divisor  = w_ipg;
                    end
                    n_state = S_DIV1;
                end
            end
            S_DIV1: begin
                if (w_div_rsp.done) begin
                    if (w_div_rsp.quotient >= 32'(w_ngroups)) begin
                        n_status = ST_INVALID;
                        n_state  = S_DONE;
                    end else begin
                        n_g = GW'(w_div_rsp.quotient);
                        if (r_cmd == CMD_FREE) begin
                            n_b     = BW'(w_div_rsp.remainder);
                            n_state = S_ADDR;
                        end else begin
                            n_left  = w_ngroups;
                            n_state = S_GRP;
                        end
                    end
                end
            end
            S_GRP: begin
                if (r_left == '0) begin
                    n_status = ST_NONE;
                    n_state  = S_DONE;
                end else if (r_gcnt[r_g] != '0) begin
                    n_b     = '0;
                    n_state = S_ADDR;
                end else begin
                    n_g    = w_g_last ? '0 : r_g + 1'b1;
                    n_left = r_left - 1'b1;
                end
            end
            S_ADDR: begin
                // The word width is a power of two, so word and offset are a plain split.
                n_word  = AW'(w_base_idx >> OW);
                n_off   = OW'(w_base_idx);
                n_state = S_RD;
            end
            S_RD: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_cmd == CMD_FREE) begin
                    w_we       = 1'b1;
                    w_wdata    = r_rdata & ~(W'(1) << r_off);
                    w_gcnt_inc = 1'b1;
                    n_state    = S_DONE;
                end else if (w_found) begin
                    w_we       = 1'b1;
                    w_wdata    = r_rdata | w_low;
                    w_gcnt_dec = 1'b1;
                    n_granted  = BLOCK_W'(32'(w_b_hit) + 32'(r_g) * 32'(w_bpg)
                                          + 32'(r_cfg_fdb));
                    n_state    = S_DONE;
                end else if (w_b_next >= BW'(w_bpg)) begin
                    n_g     = w_g_last ? '0 : r_g + 1'b1;
                    n_left  = r_left - 1'b1;
                    n_state = S_GRP;
                end else begin
                    n_b     = w_b_next;
                    n_word  = r_word + 1'b1;
                    n_off   = '0;
                    n_state = S_RD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
        r_cmd     <= n_cmd;
        r_inode   <= n_inode;
        r_blk     <= n_blk;
        r_g       <= n_g;
        r_left    <= n_left;
        r_b       <= n_b;
        r_word    <= n_word;
        r_off     <= n_off;
        r_status  <= n_status;
        r_granted <= n_granted;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[r_word];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < MAX_GROUPS; g++) begin
                r_gcnt[g] <= RST_GCNT;
            end
            r_total <= RST_TOTAL;
        end else if (w_gcnt_dec) begin
            r_gcnt[r_g] <= r_gcnt[r_g] - 1'b1;
            r_total     <= r_total - 1'b1;
        end else if (w_gcnt_inc) begin
            r_gcnt[r_g] <= r_gcnt[r_g] + 1'b1;
            r_total     <= r_total + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_bpg    <= 14'd8192;
            r_cfg_ipg    <= 17'd2048;
            r_cfg_groups <= 5'd16;
            r_cfg_fdb    <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BLOCKS_IN_GROUP:  r_cfg_bpg    <= i_cfg_data[13:0];
                CFG_INODES_IN_GROUP:  r_cfg_ipg    <= i_cfg_data;
                CFG_GROUPS_IN_USE:    r_cfg_groups <= i_cfg_data[4:0];
                CFG_FIRST_DATA_BLOCK: r_cfg_fdb    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Result register: loaded as the item finishes, freed by the downstream side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && (!r_out_valid || m_axis_tready)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (r_state == S_DONE && (!r_out_valid || m_axis_tready)) begin
            r_out_status <= r_status;
            r_out_block  <= r_granted;
            r_out_total  <= r_total;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_total, r_out_block, r_out_status};

`ifndef SYNTH
    // The bitmap clearing pass follows every reset, so no word is taken right after it.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input taken during bitmap clear");

    // One item at a time: after a word is taken the input side closes.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while busy");

    // A failed item never reports a granted block.
    a_fail_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[19:2] == '0)
        else $error("block reported on failed item");

    // Counts move only in the evaluate step.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_gcnt_dec || w_gcnt_inc) |-> r_state == S_EVAL)
        else $error("free count changed outside evaluate");
`endif

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the group bitmap block allocator.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import gbba_pkg::*;

    localparam int NGRP = 16;
    localparam int NBLK = 8192;
    localparam int PHASES = 7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BLOCK_W-1:0]  granted;
        logic [BLOCK_W-1:0]  total;
    } answer_t;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [31:0]         inode;
        logic [31:0]         blk;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [BLOCK_W-1:0]  granted;
        logic [BLOCK_W-1:0]  total;
    } dir_row_t;

    // Directed items under the reset settings: 8192 blocks and 2048 inodes per group,
    // 16 groups, data starting at block zero.
    localparam dir_row_t DIRECTED [18] = '{
        '{CMD_ALLOC, 32'd1,          32'hFFFF_FFFF, 1'b1, ST_OK,      18'd0,      18'd131071},
        '{CMD_ALLOC, 32'd0,          32'd0,         1'b1, ST_INVALID, 18'd0,      18'd131071},
        '{CMD_ALLOC, 32'hFFFF_FFFF,  32'd0,         1'b1, ST_INVALID, 18'd0,      18'd131071},
        '{CMD_ALLOC, 32'd2048,       32'd0,         1'b1, ST_OK,      18'd1,      18'd131070},
        '{CMD_ALLOC, 32'd2049,       32'd0,         1'b1, ST_OK,      18'd8192,   18'd131069},
        '{CMD_ALLOC, 32'd32768,      32'd0,         1'b1, ST_OK,      18'd122880, 18'd131068},
        '{CMD_ALLOC, 32'd32769,      32'd0,         1'b1, ST_INVALID, 18'd0,      18'd131068},
        '{CMD_FREE,  32'hFFFF_FFFF,  32'd1,         1'b1, ST_OK,      18'd0,      18'd131069},
        '{CMD_FREE,  32'd0,          32'd1,         1'b1, ST_OK,      18'd0,      18'd131070},
        '{CMD_FREE,  32'd0,          32'hFFFF_FFFF, 1'b1, ST_INVALID, 18'd0,      18'd131070},
        '{CMD_FREE,  32'd0,          32'd131071,    1'b1, ST_OK,      18'd0,      18'd131071},
        '{CMD_FREE,  32'd0,          32'd131072,    1'b1, ST_INVALID, 18'd0,      18'd131071},
        '{CMD_FREE,  32'd0,          32'd0,         1'b1, ST_OK,      18'd0,      18'd131072},
        '{CMD_ALLOC, 32'd1,          32'd0,         1'b1, ST_OK,      18'd0,      18'd131071},
        '{CMD_FREE,  32'd0,          32'd0,         1'b1, ST_OK,      18'd0,      18'd131072},
        '{CMD_FREE,  32'd0,          32'd0,         1'b1, ST_OK,      18'd0,      18'd131073},
        '{CMD_ALLOC, 32'd5000,       32'h5555_AAAA, 1'b0, ST_OK,      18'd0,      18'd0},
        '{CMD_FREE,  32'hAAAA_5555,  32'd16384,     1'b0, ST_OK,      18'd0,      18'd0}
    };

    // Register settings per phase: blocks, inodes, groups, first data block.
    localparam logic [CFG_DATA_W-1:0] PHASE_CFG [PHASES][4] = '{
        '{17'd8,       17'd1,       17'd16,      17'd0},
        '{17'd8,       17'd4,       17'd1,       17'd1},
        '{17'd8192,    17'd65536,   17'd2,       17'd1},
        '{17'd0,       17'd0,       17'd0,       17'd0},
        '{17'h1FFFF,   17'h1FFFF,   17'h1FFFF,   17'h1FFFF},
        '{17'd64,      17'd3,       17'd5,       17'd0},
        '{17'd16,      17'd2,       17'd16,      17'd1}
    };
    localparam int PHASE_ITEMS [PHASES] = '{330, 250, 300, 40, 330, 330, 350};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata = '0;   // owner_inode[31:0], block_number[63:32]
    logic [CMD_W-1:0]      s_axis_tuser = '0;   // command[0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [39:0]           m_axis_tdata;        // status[1:0], allocated_block[19:2],
                                                // free_total[37:20], zero[39:38]

    group_bitmap_block_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state.
    logic [13:0] cur_bpg = 14'd8192;
    logic [16:0] cur_ipg = 17'd2048;
    logic [4:0]  cur_groups = 5'd16;
    logic        cur_fdb = 1'b0;
    bit          used_map [NGRP][NBLK];
    logic [13:0] grp_free [NGRP];
    logic [17:0] total_free = 18'd131072;

    answer_t     pending_answers [$];
    logic [31:0] live_blocks [$];
    int          errors = 0;
    int          n_ok = 0, n_invalid = 0, n_none = 0, n_free = 0, n_words = 0;
    bit          calm = 1'b0;
    bit          hold_pending = 1'b0;

    function automatic int eff_bpg();
        if (cur_bpg == 0) return 1;
        if (cur_bpg > NBLK) return NBLK;
        return cur_bpg;
    endfunction

    function automatic int eff_groups();
        return (cur_groups > NGRP) ? NGRP : cur_groups;
    endfunction

    function automatic int unsigned eff_ipg();
        return (cur_ipg == 0) ? 1 : cur_ipg;
    endfunction

    function automatic answer_t predict_answer(input logic [CMD_W-1:0] cmd,
                                               input logic [31:0] inode,
                                               input logic [31:0] blk);
        answer_t     a;
        int unsigned bpg, ng, grp, bit_i, left;
        logic [31:0] rel;
        bit          found;
        bpg = eff_bpg();
        ng = eff_groups();
        a = '0;
        a.status = ST_OK;
        found = 1'b0;
        if (cmd == CMD_ALLOC) begin
            grp = (inode - 32'd1) / eff_ipg();
            if (grp >= ng) begin
                a.status = ST_INVALID;
            end else begin
                left = ng;
                while (left != 0 && !found) begin
                    if (grp_free[grp] != 0) begin
                        for (bit_i = 0; bit_i < bpg; bit_i++)
                            if (!used_map[grp][bit_i]) break;
                        if (bit_i < bpg) begin
                            used_map[grp][bit_i] = 1'b1;
                            grp_free[grp] = grp_free[grp] - 14'd1;
                            total_free = total_free - 18'd1;
                            a.granted = BLOCK_W'(bit_i + grp * bpg + cur_fdb);
                            found = 1'b1;
                        end
                    end
                    if (!found) begin
                        grp = (grp + 1 >= ng) ? 0 : grp + 1;
                        left--;
                    end
                end
                if (!found) a.status = ST_NONE;
            end
        end else begin
            rel = blk - 32'(cur_fdb);
            grp = rel / bpg;
            if (grp >= ng) begin
                a.status = ST_INVALID;
            end else begin
                used_map[grp][rel % bpg] = 1'b0;
                grp_free[grp] = grp_free[grp] + 14'd1;
                total_free = total_free + 18'd1;
            end
        end
        a.total = total_free;
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (errors < 40)
            $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Result checker; values are sampled as they stood before the edge.
    always @(posedge i_clk) begin
        answer_t want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result word", m_axis_tdata[31:0], 0);
            end else begin
                want = pending_answers.pop_front();
                if (m_axis_tdata[1:0] !== want.status)
                    report_mismatch("status", m_axis_tdata[1:0], want.status);
                if (m_axis_tdata[19:2] !== want.granted)
                    report_mismatch("allocated_block", m_axis_tdata[19:2], want.granted);
                if (m_axis_tdata[37:20] !== want.total)
                    report_mismatch("free_total", m_axis_tdata[37:20], want.total);
                if (m_axis_tdata[39:38] !== 2'b00)
                    report_mismatch("pad bits", m_axis_tdata[39:38], 0);
            end
        end
    end

    // Result receiver with random stalls and one long hold-off on request.
    initial begin
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    // Sends one word, then records what the block should answer.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [31:0] inode,
                             input logic [31:0] blk, input bit typed, input answer_t typed_a);
        answer_t a;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {blk, inode};
        do @(posedge i_clk); while (!s_axis_tready);
        a = predict_answer(cmd, inode, blk);
        if (cmd == CMD_ALLOC && a.status == ST_OK) live_blocks.push_back(32'(a.granted));
        if (a.status == ST_OK && cmd == CMD_ALLOC) n_ok++;
        if (a.status == ST_INVALID) n_invalid++;
        if (a.status == ST_NONE) n_none++;
        if (cmd == CMD_FREE && a.status == ST_OK) n_free++;
        n_words++;
        pending_answers.push_back(typed ? typed_a : a);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (pending_answers.size() == 0);
        @(posedge i_clk);
    endtask

    task automatic load_settings(input int ph);
        for (int r = 0; r < 4; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(r);
            i_cfg_data  <= PHASE_CFG[ph][r];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (CFG_IDX_W'(r))
                CFG_BLOCKS_IN_GROUP:  cur_bpg    = PHASE_CFG[ph][r][13:0];
                CFG_INODES_IN_GROUP:  cur_ipg    = PHASE_CFG[ph][r][16:0];
                CFG_GROUPS_IN_USE:    cur_groups = PHASE_CFG[ph][r][4:0];
                CFG_FIRST_DATA_BLOCK: cur_fdb    = PHASE_CFG[ph][r][0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
        live_blocks.delete();
    endtask

    // Mostly well-formed allocates and frees of granted blocks, with some noise.
    task automatic send_random();
        int unsigned pick, idx;
        longint      span;
        logic [31:0] inode, blk;
        pick = $urandom_range(0, 99);
        inode = $urandom();
        blk = $urandom();
        span = longint'(eff_groups()) * eff_ipg();
        if (pick < 48) begin
            if (span > 0) inode = 32'(1 + {$urandom(), $urandom()} % span);
            send_word(CMD_ALLOC, inode, blk, 1'b0, '0);
        end else if (pick < 82 && live_blocks.size() > 0) begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            blk = live_blocks[idx];
            live_blocks.delete(idx);
            send_word(CMD_FREE, inode, blk, 1'b0, '0);
        end else if (pick < 92) begin
            blk = $urandom_range(0, eff_groups() * eff_bpg() + 1);
            send_word(CMD_FREE, inode, blk, 1'b0, '0);
        end else begin
            send_word(($urandom_range(0, 1) == 0) ? CMD_ALLOC : CMD_FREE, inode, blk,
                      1'b0, '0);
        end
    endtask

    initial begin
        answer_t ta;
        for (int g = 0; g < NGRP; g++) grp_free[g] = 14'(NBLK);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (DIRECTED[k]) begin
            ta.status = DIRECTED[k].status;
            ta.granted = DIRECTED[k].granted;
            ta.total = DIRECTED[k].total;
            send_word(DIRECTED[k].cmd, DIRECTED[k].inode, DIRECTED[k].blk,
                      DIRECTED[k].typed, ta);
        end
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            load_settings(ph);
            if (ph == PHASES - 1) calm = 1'b1;
            if (ph == 2) hold_pending = 1'b1;
            for (int n = 0; n < PHASE_ITEMS[ph]; n++) send_random();
        end
        s_axis_tvalid <= 1'b0;
        wait (pending_answers.size() == 0);
        repeat (300) @(posedge i_clk);
        errors += pending_answers.size();
        $display("Covered %0d words over %0d register settings: %0d granted, %0d freed,",
                 n_words, PHASES + 1, n_ok, n_free);
        $display("%0d rejected for a bad group, %0d with no block left.", n_invalid, n_none);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Run timed out with %0d results outstanding.", pending_answers.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
sv/gbba_pkg.sv
sv/gbba_divider.sv
sv/group_bitmap_block_allocator.sv
tb/tb.sv
